FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the mosaic packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/bmp12_pkg.sv
// Package: types and constants of the Bayer mosaic 12-bit packer.
`timescale 1ns / 1ps
package bmp12_pkg;

    // Image limits
    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 3072;

    // Field and register widths
    localparam int ChanW   = 8;
    localparam int SampleW = 12;
    localparam int WidthW  = 13;
    localparam int HeightW = 12;
    localparam int PosW    = 12;
    localparam int CfgW    = 13;
    localparam int IdxW    = 1;

    // Register reset values
    localparam logic [WidthW-1:0]  RowWidthRst = WidthW'(2048);
    localparam logic [HeightW-1:0] RowTotalRst = HeightW'(1536);

    // Register indexes
    localparam logic [IdxW-1:0] RegRowWidth = 1'b0;
    localparam logic [IdxW-1:0] RegRowTotal = 1'b1;

    // Output byte queue
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCntW   = $clog2(QDepth + 1);
    localparam int MaxBeats = 3;

    // One output beat
    typedef struct packed {
        logic [7:0] data;
        logic       last_of_run;
        logic       row_end;
        logic       frame_end;
    } t_beat;

endpackage

FILE: hw/rtl/bayer_mosaic_12bit_packer_top.sv
// Top level: RGGB mosaic sampler with 12-bit big-endian byte packing.
`timescale 1ns / 1ps
// Usage:
//   Pixel channel: i_valid / o_stall carry one RGB pixel per beat in raster order.
//   Byte channel:  o_valid / i_stall carry one packed byte per beat with its
//   last_of_run, row_end and frame_end flags.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 row_width,
//   1 row_total); write only while no pixel is in flight.
// Queue: a pixel's bytes are registered into the byte queue when it is accepted.
// Throughput: a pixel that only fills the holding register is taken in any
//   cycle; a pixel that emits bytes needs room for three bytes in the 4-entry
//   byte queue, so pixels are taken while earlier bytes still drain; the
//   output port sends one byte per cycle while i_stall is low.
// Reset: position, held sample and queue clear; row_width = 2048,
//   row_total = 1536.
// Receiver stall: bytes wait in the queue with the head byte held steady;
//   once two or more bytes wait, o_stall rises for pixels that would emit bytes.
`include "assert_macros.svh"

module bayer_mosaic_12bit_packer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [bmp12_pkg::IdxW-1:0]    i_cfg_idx,
    input  logic [bmp12_pkg::CfgW-1:0]    i_cfg_data,
    // pixel channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bmp12_pkg::ChanW-1:0]   i_red,
    input  logic [bmp12_pkg::ChanW-1:0]   i_green,
    input  logic [bmp12_pkg::ChanW-1:0]   i_blue,
    // byte channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_of_run,
    output logic                          o_row_end,
    output logic                          o_frame_end
);

    // Config registers
    logic [bmp12_pkg::WidthW-1:0]  r_row_width;
    logic [bmp12_pkg::HeightW-1:0] r_row_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= bmp12_pkg::RowWidthRst;
            r_row_total <= bmp12_pkg::RowTotalRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmp12_pkg::RegRowWidth: r_row_width <= i_cfg_data;
                bmp12_pkg::RegRowTotal: r_row_total <= i_cfg_data[bmp12_pkg::HeightW-1:0];
                default: ;
            endcase
        end
    end

    // Saturated width and height in use
    logic [bmp12_pkg::WidthW-1:0] width_use;
    logic [bmp12_pkg::WidthW-1:0] height_use;

    always_comb begin
        if (r_row_width == '0)
            width_use = bmp12_pkg::WidthW'(1);
        else if (r_row_width > bmp12_pkg::WidthW'(bmp12_pkg::MaxWidth))
            width_use = bmp12_pkg::WidthW'(bmp12_pkg::MaxWidth);
        else
            width_use = r_row_width;

        if (r_row_total == '0)
            height_use = bmp12_pkg::WidthW'(1);
        else if (r_row_total > bmp12_pkg::HeightW'(bmp12_pkg::MaxHeight))
            height_use = bmp12_pkg::WidthW'(bmp12_pkg::MaxHeight);
        else
            height_use = {1'b0, r_row_total};
    end

    // Scan position and held sample
    logic [bmp12_pkg::PosW-1:0]    r_col;
    logic [bmp12_pkg::PosW-1:0]    r_row;
    logic [bmp12_pkg::SampleW-1:0] r_held;
    logic                          r_held_valid;

    logic row_last;
    logic frame_last;
    logic zero_out;
    logic in_acc;

    assign row_last   = ({1'b0, r_col} + bmp12_pkg::WidthW'(1)) >= width_use;
    assign frame_last = row_last && (({1'b0, r_row} + bmp12_pkg::WidthW'(1)) >= height_use);
    // pixel only fills the holding register
    assign zero_out   = !r_held_valid && !row_last;

    // Byte queue state
    bmp12_pkg::t_beat              r_q [bmp12_pkg::QDepth];
    logic [bmp12_pkg::QPtrW-1:0]   r_wr_ptr;
    logic [bmp12_pkg::QPtrW-1:0]   r_rd_ptr;
    logic [bmp12_pkg::QCntW-1:0]   r_count;

    assign o_stall = !(zero_out || (r_count <= bmp12_pkg::QCntW'(1)));
    assign in_acc  = i_valid && !o_stall;

    // Mosaic channel select and beat build
    logic [bmp12_pkg::ChanW-1:0]   chan;
    bmp12_pkg::t_beat              n_beats [bmp12_pkg::MaxBeats];
    logic [1:0]                    n_push;

    always_comb begin
        if (!r_row[0])
            chan = r_col[0] ? i_green : i_red;
        else
            chan = r_col[0] ? i_blue : i_green;

        for (int k = 0; k < bmp12_pkg::MaxBeats; k++) begin
            n_beats[k] = '0;
        end
        n_push = 2'd0;

        if (r_held_valid) begin
            n_beats[0].data        = r_held[11:4];
            n_beats[1].data        = {r_held[3:0], chan[7:4]};
            n_beats[2].data        = {chan[3:0], 4'b0000};
            n_beats[2].last_of_run = 1'b1;
            n_beats[2].row_end     = row_last;
            n_beats[2].frame_end   = frame_last;
            n_push                 = 2'd3;
        end else if (row_last) begin
            // lone sample at row end: two bytes
            n_beats[0].data        = {4'b0000, chan[7:4]};
            n_beats[1].data        = {chan[3:0], 4'b0000};
            n_beats[1].last_of_run = 1'b1;
            n_beats[1].row_end     = 1'b1;
            n_beats[1].frame_end   = frame_last;
            n_push                 = 2'd2;
        end
    end

    // Position and holding register update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else if (in_acc) begin
            if (row_last) begin
                r_col        <= '0;
                r_row        <= frame_last ? '0 : r_row + bmp12_pkg::PosW'(1);
                r_held       <= '0;
                r_held_valid <= 1'b0;
            end else begin
                r_col <= r_col + bmp12_pkg::PosW'(1);
                if (r_held_valid) begin
                    r_held       <= '0;
                    r_held_valid <= 1'b0;
                end else begin
                    r_held       <= {chan, 4'b0000};
                    r_held_valid <= 1'b1;
                end
            end
        end
    end

    // Queue pointers and fill count
    logic                          out_acc;
    logic [1:0]                    push_n;

    assign out_acc = o_valid && !i_stall;
    assign push_n  = in_acc ? n_push : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + bmp12_pkg::QPtrW'(push_n);
            r_rd_ptr <= r_rd_ptr + bmp12_pkg::QPtrW'(out_acc);
            r_count  <= r_count + bmp12_pkg::QCntW'(push_n) - bmp12_pkg::QCntW'(out_acc);
        end
    end

    // Queue payload, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bmp12_pkg::MaxBeats; k++) begin
            if (bmp12_pkg::QCntW'(k) < bmp12_pkg::QCntW'(push_n))
                r_q[r_wr_ptr + bmp12_pkg::QPtrW'(k)] <= n_beats[k];
        end
    end

    // Head of queue drives the byte channel
    bmp12_pkg::t_beat head;
    assign head          = r_q[r_rd_ptr];
    assign o_valid       = (r_count != '0);
    assign o_out_byte    = head.data;
    assign o_last_of_run = head.last_of_run;
    assign o_row_end     = head.row_end;
    assign o_frame_end   = head.frame_end;

    // Checks
    `ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= bmp12_pkg::QCntW'(bmp12_pkg::QDepth))
    `ASSERT_IMPL(a_fend_flags, i_clk, i_rst_n, o_valid && o_frame_end, o_row_end && o_last_of_run)
    `ASSERT_NEXT(a_row_wrap, i_clk, i_rst_n, in_acc && row_last, r_col == '0 && !r_held_valid)
    `ASSERT_NEXT(a_pair_push, i_clk, i_rst_n, in_acc && r_held_valid, r_count >= bmp12_pkg::QCntW'(2))

endmodule
